/* src/assert_macros.svh */
// assertion helpers for the ordered set table
// clocked check with a reset that disables it, and a check with no reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif
`endif

/* src/ost_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ost_pkg
// shared widths, codes and types of the ordered set table
// ----------------------------------------------------------------------------
package ost_pkg;

  // table geometry
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 2;
  localparam int POS_W    = 5;
  localparam int STAT_W   = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_DONE   = 2'd0,
    STAT_DUP    = 2'd1,
    STAT_ABSENT = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_t;

  // per-cell control
  typedef struct packed {
    logic compare;
    logic insert_here;
    logic shift;
  } cell_ctrl_t;

endpackage

/* src/ost_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ost_if
// request and response channels of the ordered set table
// ----------------------------------------------------------------------------

// request channel: operation and value
interface ost_req_if import ost_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

// response channel: lookup result and entry count
interface ost_rsp_if import ost_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [POS_W-1:0]  position;
  logic [POS_W-1:0]  entry_count;
  logic [STAT_W-1:0] status;

  modport source (output valid, output found, output position, output entry_count,
                  output status, input ready);
  modport sink   (input valid, input found, input position, input entry_count,
                  input status, output ready);
endinterface

/* src/ordered_set_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_set_table
// insertion-ordered set of distinct 32-bit values in a row of compare cells
// ----------------------------------------------------------------------------
// channel  dir  fields
// req      in   operation, value
// rsp      out  found, position, entry_count, status
//
// each transaction steps through accept, compare in every cell, update;
// the update step waits while a previous response is still held in rsp
// the compare is registered in each cell, and the hit chain runs along
// the row of cells to locate and shift
// rst is synchronous; it empties the table, entries need no clearing
module ordered_set_table import ost_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ost_req_if.sink    req,
  ost_rsp_if.source  rsp
);

`include "assert_macros.svh"

  state_t state, state_next;

  logic [OP_W-1:0]          op_q;
  logic signed [DATA_W-1:0] key_q;
  logic [CNT_W-1:0]         count, count_next;

  logic                     req_ready;
  logic                     compare;
  logic                     exec_go;

  logic signed [DATA_W-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]      match_vec;
  logic [CAPACITY:0]        hit;
  cell_ctrl_t               cell_ctrl [CAPACITY];

  logic                     found;
  logic                     full;
  logic [CNT_W-1:0]         pos;
  logic                     do_insert;
  logic                     do_remove;
  status_t                  status;

  logic                     rsp_valid;
  logic                     rsp_found;
  logic [POS_W-1:0]         rsp_position;
  logic [POS_W-1:0]         rsp_count;
  status_t                  rsp_status;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req.valid) state_next = S_CMP;
      S_CMP:  state_next = S_EXEC;
      S_EXEC: if (!rsp_valid || rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_ready = 1'b0;
    compare   = 1'b0;
    exec_go   = 1'b0;
    unique case (state)
      S_IDLE: req_ready = 1'b1;
      S_CMP:  compare = 1'b1;
      S_EXEC: exec_go = !rsp_valid || rsp.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req.ready = req_ready;

  // request capture
  always_ff @(posedge clk) begin
    if (req.valid && req_ready) begin
      op_q  <= req.operation;
      key_q <= req.value;
    end
  end

  // row of cells
  assign hit[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_ctrl[i].compare     = compare;
    assign cell_ctrl[i].insert_here = do_insert && (count == CNT_W'(i));
    assign cell_ctrl[i].shift       = do_remove;

    ost_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (cell_ctrl[i]),
      .live       (CNT_W'(i) < count),
      .key        (key_q),
      .next_entry (entries[(i + 1 < CAPACITY) ? i + 1 : i]),
      .hit_in     (hit[i]),
      .entry      (entries[i]),
      .match      (match_vec[i]),
      .hit_out    (hit[i+1])
    );
  end

  // position of the single match
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_vec[i]) pos = pos | CNT_W'(i + 1);
    end
  end

  assign found = hit[CAPACITY];
  assign full  = (count == CNT_W'(CAPACITY));

  // operation decode
  always_comb begin
    do_insert  = 1'b0;
    do_remove  = 1'b0;
    count_next = count;
    case (op_q)
      OP_INSERT: begin
        if (found) begin
          status = STAT_DUP;
        end else if (full) begin
          status = STAT_FULL;
        end else begin
          status     = STAT_DONE;
          do_insert  = exec_go;
          count_next = count + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (found) begin
          status     = STAT_DONE;
          do_remove  = exec_go;
          count_next = count - CNT_W'(1);
        end else begin
          status = STAT_ABSENT;
        end
      end
      default: status = found ? STAT_DONE : STAT_ABSENT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (exec_go) begin
      count <= count_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      rsp_found    <= found;
      rsp_position <= POS_W'(pos);
      rsp_count    <= POS_W'(count_next);
      rsp_status   <= status;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.found       = rsp_found;
  assign rsp.position    = rsp_position;
  assign rsp.entry_count = rsp_count;
  assign rsp.status      = rsp_status;

  // checks
  `ASSERT_CLK_RST(a_count_bound, clk, rst, count <= CNT_W'(CAPACITY), "count above capacity")
  `ASSERT_CLK_RST(a_single_match, clk, rst, state == S_EXEC |-> $onehot0(match_vec), "value held twice")
  `ASSERT_CLK_RST(a_insert_count, clk, rst, do_insert |=> count == $past(count) + CNT_W'(1), "insert lost")

endmodule

/* src/ost_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ost_cell
// one table entry: holds a value, compares it with the key and shifts down
// ----------------------------------------------------------------------------
module ost_cell import ost_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cell_ctrl_t               ctrl,
  input  logic                     live,
  input  logic signed [DATA_W-1:0] key,
  input  logic signed [DATA_W-1:0] next_entry,
  input  logic                     hit_in,
  output logic signed [DATA_W-1:0] entry,
  output logic                     match,
  output logic                     hit_out
);

  // a hit at this cell or any earlier one
  assign hit_out = hit_in | match;

  // registered compare against the key
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.compare) begin
      match <= live && (entry == key);
    end
  end

  // append here, or take the neighbor's value to close a gap
  always_ff @(posedge clk) begin
    if (ctrl.insert_here) begin
      entry <= key;
    end else if (ctrl.shift && hit_out) begin
      entry <= next_entry;
    end
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// ordered set table: insert, remove and query traffic checked per transaction
// a directed opening covers empty and full tables, duplicates, absent values,
// shifts on remove and the spare operation code; random traffic then draws
// from small value pools so the table fills, drains and overflows, while both
// channels stall at random and each response is compared with a set model
// ----------------------------------------------------------------------------
module testbench;
  import ost_pkg::*;

  // spare operation code, handled as a query
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 1200;

  localparam logic [DATA_W-1:0] V_MIN  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] V_MAX  = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] V_NEG1 = 32'hffff_ffff;

  // one pending request and the stall settings that go with it
  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
    bit                hold;
    int                snd_idle;
    int                rcv_idle;
  } request_t;

  // one expected response
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] entry_count;
    status_t          status;
  } answer_t;

  logic clk = 1'b0;
  logic rst;

  ost_req_if req_ch ();
  ost_rsp_if rsp_ch ();

  ordered_set_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  request_t          request_q[$];
  answer_t           answer_q[$];
  logic [DATA_W-1:0] value_pool[$];

  // set model state
  logic [DATA_W-1:0] set_entries [CAPACITY];
  int                set_count = 0;

  int items_accepted  = 0;
  int answers_checked = 0;
  int fail_count      = 0;
  int cycle_count     = 0;
  int rcv_idle_pct    = 0;

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // set model: response of one transaction, state updated in place
  function automatic answer_t predict_answer(logic [OP_W-1:0] op, logic [DATA_W-1:0] v);
    answer_t a;
    int      pos;
    pos = 0;
    for (int i = 0; i < set_count; i++) begin
      if (pos == 0 && set_entries[i] == v) pos = i + 1;
    end
    a.found    = (pos != 0);
    a.position = pos[POS_W-1:0];
    case (op)
      OP_INSERT: begin
        if (pos != 0) begin
          a.status = STAT_DUP;
        end else if (set_count >= CAPACITY) begin
          a.status = STAT_FULL;
        end else begin
          set_entries[set_count] = v;
          set_count++;
          a.status = STAT_DONE;
        end
      end
      OP_REMOVE: begin
        if (pos == 0) begin
          a.status = STAT_ABSENT;
        end else begin
          // close the gap left by the removed entry
          for (int i = pos - 1; i < set_count - 1; i++) set_entries[i] = set_entries[i + 1];
          set_count--;
          a.status = STAT_DONE;
        end
      end
      default: begin
        a.status = (pos != 0) ? STAT_DONE : STAT_ABSENT;
      end
    endcase
    a.entry_count = set_count[POS_W-1:0];
    return a;
  endfunction

  task automatic add_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] v, bit hold,
                             int snd, int rcv);
    request_t r;
    r.op       = op;
    r.value    = v;
    r.hold     = hold;
    r.snd_idle = snd;
    r.rcv_idle = rcv;
    request_q.push_back(r);
  endtask

  // random value with a bias toward the extremes
  function automatic logic [DATA_W-1:0] fresh_value();
    case ($urandom_range(7))
      0:       return V_MIN;
      1:       return V_MAX;
      2:       return '0;
      3:       return V_NEG1;
      default: return $urandom;
    endcase
  endfunction

  // random traffic: epochs over a value pool, filling first, then draining
  task automatic add_random_phase(int snd, int rcv, int n);
    int                made;
    int                epoch_len;
    int                epoch_pos;
    int                r;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] v;
    bit                hold;
    made      = 0;
    epoch_len = 0;
    epoch_pos = 0;
    hold      = 1'b1;
    while (made < n) begin
      if (epoch_pos == epoch_len) begin
        // clear out the old pool, then draw a new one
        foreach (value_pool[i]) begin
          add_request(OP_REMOVE, value_pool[i], hold, snd, rcv);
          hold = 1'b0;
          made++;
        end
        value_pool.delete();
        repeat ($urandom_range(22, 3)) value_pool.push_back(fresh_value());
        epoch_len = $urandom_range(120, 40);
        epoch_pos = 0;
      end
      r = $urandom_range(99);
      v = value_pool[$urandom_range(value_pool.size() - 1)];
      if (r < 10) begin
        // noise: remove or look up an arbitrary value
        op = OP_W'($urandom_range(3, 1));
        v  = $urandom;
      end else if (r < 20) begin
        op = $urandom_range(1) ? OP_QUERY : OP_SPARE;
      end else if ((epoch_pos < epoch_len / 2) == (r < 70)) begin
        op = OP_INSERT;
      end else begin
        op = OP_REMOVE;
      end
      add_request(op, v, hold || ($urandom_range(99) == 0), snd, rcv);
      hold = 1'b0;
      made++;
      epoch_pos++;
    end
  endtask

  // request driver
  always @(posedge clk) begin : drive_requests
    request_t nxt;
    if (rst) begin
      req_ch.valid     <= 1'b0;
      req_ch.operation <= OP_QUERY;
      req_ch.value     <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        answer_q.push_back(predict_answer(req_ch.operation, req_ch.value));
        items_accepted <= items_accepted + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (request_q.size() != 0 &&
            (!request_q[0].hold ||
             (!(req_ch.valid && req_ch.ready) && items_accepted == answers_checked)) &&
            $urandom_range(99) >= request_q[0].snd_idle) begin
          nxt = request_q.pop_front();
          req_ch.valid     <= 1'b1;
          req_ch.operation <= nxt.op;
          req_ch.value     <= nxt.value;
          rcv_idle_pct     <= nxt.rcv_idle;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and checker
  always @(posedge clk) begin : check_answers
    answer_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (answer_q.size() == 0) begin
          $error("response transaction with no request outstanding");
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          if (rsp_ch.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, rsp_ch.found);
            fail_count++;
          end
          if (rsp_ch.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, rsp_ch.position);
            fail_count++;
          end
          if (rsp_ch.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, rsp_ch.entry_count);
            fail_count++;
          end
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            fail_count++;
          end
        end
        answers_checked <= answers_checked + 1;
      end
      rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ordered_set_table test failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    rst = 1'b1;

    // empty table lookups
    add_request(OP_QUERY, '0, 1'b0, 20, 48);
    add_request(OP_REMOVE, 32'd5, 1'b0, 20, 48);
    // extremes, zero and minus one, then a duplicate
    add_request(OP_INSERT, V_MIN, 1'b0, 20, 48);
    add_request(OP_INSERT, V_MAX, 1'b0, 20, 48);
    add_request(OP_INSERT, '0, 1'b0, 20, 48);
    add_request(OP_INSERT, V_NEG1, 1'b0, 20, 48);
    add_request(OP_INSERT, V_MIN, 1'b0, 20, 48);
    // spare code behaves as a query
    add_request(OP_SPARE, V_MAX, 1'b0, 20, 48);
    // remove from the middle, then check the shift
    add_request(OP_REMOVE, '0, 1'b0, 20, 48);
    add_request(OP_QUERY, V_NEG1, 1'b0, 20, 48);
    // fill up to capacity
    for (int i = 0; i < CAPACITY - 3; i++) add_request(OP_INSERT, 100 + i, 1'b0, 20, 48);
    // new value into a full table, duplicate into a full table
    add_request(OP_INSERT, 32'd7, 1'b1, 20, 48);
    add_request(OP_INSERT, V_NEG1, 1'b0, 20, 48);
    // remove the first entry so every other one shifts
    add_request(OP_REMOVE, V_MIN, 1'b0, 20, 48);

    // first random pool holds the values left in the table and the two removed ones
    value_pool.push_back(V_MIN);
    value_pool.push_back(V_MAX);
    value_pool.push_back('0);
    value_pool.push_back(V_NEG1);
    for (int i = 0; i < CAPACITY - 3; i++) value_pool.push_back(100 + i);

    add_random_phase(20, 48, RANDOM_ITEMS / 3);
    add_random_phase(48, 20, RANDOM_ITEMS / 3);
    add_random_phase(0, 0, RANDOM_ITEMS / 3);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (request_q.size() != 0 || req_ch.valid || items_accepted != answers_checked);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && answer_q.size() == 0) begin
      $display("ordered_set_table test passed");
    end else begin
      $display("ordered_set_table test failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/ost_pkg.sv
src/ost_if.sv
src/ost_cell.sv
src/ordered_set_table.sv
bench/testbench.sv
